// ===== hdl/tek_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tek_pkg;

    localparam int CW = 10;
    localparam int FW = 4;

    localparam logic [FW-1:0] F_ADD     = 4'd0;
    localparam logic [FW-1:0] F_DEL     = 4'd1;
    localparam logic [FW-1:0] F_QUERY   = 4'd2;
    localparam logic [FW-1:0] F_TWO     = 4'd3;
    localparam logic [FW-1:0] F_THREE   = 4'd4;
    localparam logic [FW-1:0] F_FOUR    = 4'd5;
    localparam logic [FW-1:0] F_BETWEEN = 4'd6;
    localparam logic [FW-1:0] F_CLEAR   = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_REJ   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // operand slots in the item
    localparam logic [2:0] OA = 3'd0;
    localparam logic [2:0] OB = 3'd1;
    localparam logic [2:0] OC = 3'd2;
    localparam logic [2:0] OD = 3'd3;
    localparam logic [2:0] OE = 3'd4;
    localparam logic [2:0] OF = 3'd5;
    localparam logic [2:0] OG = 3'd6;
    localparam logic [2:0] OH = 3'd7;

    typedef struct packed {
        logic          v1;
        logic [CW-1:0] c1;
        logic          v0;
        logic [CW-1:0] c0;
    } t_ent;

    typedef struct packed {
        logic [2:0] x;
        logic [2:0] y;
        logic       add;
        logic       last;
    } t_step;

    typedef enum logic [1:0] {RS_X, RS_Y, RS_A, RS_CUR} t_rsrc;
    typedef enum logic [1:0] {WS_NONE, WS_X, WS_Y, WS_CLR} t_wsel;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_rsrc      rd_src;
        logic       lat_a;
        logic       lat_b;
        t_wsel      wr;
        logic [2:0] step;
        logic       edge_done;
        logic       walk_init;
        logic       walk_adv;
        logic       ans_set;
        logic       ans_val;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [FW-1:0] func;
        logic          range_bad;
        logic          step_last;
        logic          trivial;
        logic          w_done;
        logic          w_ans;
        logic          clr_last;
    } t_sts;

    function automatic t_step mk(input logic [2:0] x, input logic [2:0] y,
                                 input logic add, input logic last);
        t_step s;
        s.x = x;
        s.y = y;
        s.add = add;
        s.last = last;
        return s;
    endfunction

    // edge steps of each operation: deletes first, then adds
    function automatic t_step step_info(input logic [FW-1:0] f, input logic [2:0] k);
        t_step s;
        s = mk(OA, OB, 1'b0, 1'b1);
        unique case (f)
            F_ADD: s = mk(OA, OB, 1'b1, 1'b1);
            F_TWO: begin
                unique case (k)
                    3'd0:    s = mk(OA, OB, 1'b0, 1'b0);
                    3'd1:    s = mk(OC, OD, 1'b0, 1'b0);
                    3'd2:    s = mk(OA, OD, 1'b1, 1'b0);
                    default: s = mk(OB, OC, 1'b1, 1'b1);
                endcase
            end
            F_THREE: begin
                unique case (k)
                    3'd0:    s = mk(OA, OB, 1'b0, 1'b0);
                    3'd1:    s = mk(OC, OD, 1'b0, 1'b0);
                    3'd2:    s = mk(OE, OF, 1'b0, 1'b0);
                    3'd3:    s = mk(OA, OF, 1'b1, 1'b0);
                    3'd4:    s = mk(OB, OC, 1'b1, 1'b0);
                    default: s = mk(OD, OE, 1'b1, 1'b1);
                endcase
            end
            F_FOUR: begin
                unique case (k)
                    3'd0:    s = mk(OA, OB, 1'b0, 1'b0);
                    3'd1:    s = mk(OC, OD, 1'b0, 1'b0);
                    3'd2:    s = mk(OE, OF, 1'b0, 1'b0);
                    3'd3:    s = mk(OG, OH, 1'b0, 1'b0);
                    3'd4:    s = mk(OA, OH, 1'b1, 1'b0);
                    3'd5:    s = mk(OB, OC, 1'b1, 1'b0);
                    3'd6:    s = mk(OD, OE, 1'b1, 1'b0);
                    default: s = mk(OF, OG, 1'b1, 1'b1);
                endcase
            end
            default: s = mk(OA, OB, 1'b0, 1'b1);
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tek_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tek_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire tek_pkg::t_sts i_sts,
    output tek_pkg::t_cmd      o_cmd
);
    import tek_pkg::*;

    typedef enum logic [3:0] {
        S_RST, S_IDLE, S_DISP, S_ERDX, S_ERDY, S_ELAT, S_EWRX, S_EWRY,
        S_WRD, S_WCHK, S_CLEAR, S_FRD, S_FLAT, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step;
    logic       r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.step = r_step;
        n_state = r_state;
        unique case (r_state)
            S_RST: begin
                o_cmd.wr = WS_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.range_bad) begin
                    n_state = S_FRD;
                end else begin
                    unique case (i_sts.func)
                        F_ADD, F_DEL, F_TWO, F_THREE, F_FOUR: n_state = S_ERDX;
                        F_BETWEEN: begin
                            if (i_sts.trivial) begin
                                o_cmd.ans_set = 1'b1;
                                o_cmd.ans_val = 1'b1;
                                n_state = S_FRD;
                            end else begin
                                o_cmd.walk_init = 1'b1;
                                n_state = S_WRD;
                            end
                        end
                        F_CLEAR: n_state = S_CLEAR;
                        default: n_state = S_FRD;
                    endcase
                end
            end
            S_ERDX: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_src = RS_X;
                n_state = S_ERDY;
            end
            S_ERDY: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_src = RS_Y;
                o_cmd.lat_a = 1'b1;
                n_state = S_ELAT;
            end
            S_ELAT: begin
                o_cmd.lat_b = 1'b1;
                n_state = S_EWRX;
            end
            S_EWRX: begin
                o_cmd.wr = WS_X;
                n_state = S_EWRY;
            end
            S_EWRY: begin
                o_cmd.wr = WS_Y;
                o_cmd.edge_done = 1'b1;
                n_state = i_sts.step_last ? S_FRD : S_ERDX;
            end
            S_WRD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_src = RS_CUR;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (i_sts.w_done) begin
                    o_cmd.ans_set = 1'b1;
                    o_cmd.ans_val = i_sts.w_ans;
                    n_state = S_FRD;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_CLEAR: begin
                o_cmd.wr = WS_CLR;
                if (i_sts.clr_last) n_state = S_FRD;
            end
            S_FRD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_src = RS_A;
                n_state = S_FLAT;
            end
            S_FLAT: begin
                o_cmd.lat_a = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST;
            r_step <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DISP) begin
                r_step <= '0;
            end else if (r_state == S_EWRY && !i_sts.step_last) begin
                r_step <= r_step + 3'd1;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hdl/tek_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tek_dp #(
    parameter int MAX_CITIES = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tek_pkg::t_cmd            i_cmd,
    output tek_pkg::t_sts                 o_sts,
    input  wire logic [10:0]              i_count,
    input  wire logic [tek_pkg::FW-1:0]   i_func,
    input  wire logic [8*tek_pkg::CW-1:0] i_ops,
    output logic [1:0]                    o_status,
    output logic                          o_answer,
    output logic [1:0]                    o_degree
);
    import tek_pkg::*;

    localparam int AW = $clog2(MAX_CITIES);
    localparam int NW = $clog2(MAX_CITIES + 1);

    t_ent mem [MAX_CITIES];

    logic [FW-1:0]   r_func;
    logic [8*CW-1:0] r_ops;
    t_ent            r_rdata, r_ra, r_rb;
    logic [CW-1:0]   r_prev, r_cur;
    logic [NW-1:0]   r_steps;
    logic [AW-1:0]   r_clr;
    logic            r_err, r_ans;
    logic [1:0]      r_status, r_degree;
    logic            r_answer;

    logic [NW-1:0] w_n;
    t_step         w_step;
    logic [CW-1:0] w_x, w_y, w_a, w_b, w_c, w_d, w_next, w_rd_city;
    logic [3:0]    w_used;
    logic          w_bad, w_has, w_ok, w_fok, w_sok, w_dead, w_slast, w_has_ab;
    t_ent          w_na, w_nb;

    function automatic logic [CW-1:0] op(input logic [8*CW-1:0] v, input logic [2:0] i);
        return v[i*CW +: CW];
    endfunction

    always_comb begin
        w_n = (32'(i_count) < MAX_CITIES) ? NW'(i_count) : NW'(MAX_CITIES);
        w_a = op(r_ops, OA);
        w_b = op(r_ops, OB);
        w_c = op(r_ops, OC);
        w_d = op(r_ops, OD);
        w_step = step_info(r_func, i_cmd.step);
        w_x = op(r_ops, w_step.x);
        w_y = op(r_ops, w_step.y);

        unique case (r_func)
            F_ADD, F_DEL, F_QUERY: w_used = 4'd2;
            F_TWO, F_BETWEEN:      w_used = 4'd4;
            F_THREE:               w_used = 4'd6;
            F_FOUR:                w_used = 4'd8;
            default:               w_used = 4'd0;
        endcase
        w_bad = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i < 32'(w_used) && 32'(op(r_ops, 3'(i))) >= 32'(w_n)) w_bad = 1'b1;
        end

        // edge step on the two latched entries
        w_has = (r_ra.v0 && r_ra.c0 == w_y) || (r_ra.v1 && r_ra.c1 == w_y);
        w_na = r_ra;
        w_nb = r_rb;
        if (w_step.add) begin
            w_ok = (w_x != w_y) && !w_has && !(r_ra.v0 && r_ra.v1)
                   && !(r_rb.v0 && r_rb.v1);
            if (!r_ra.v0) begin
                w_na.v0 = 1'b1;
                w_na.c0 = w_y;
            end else begin
                w_na.v1 = 1'b1;
                w_na.c1 = w_y;
            end
            if (!r_rb.v0) begin
                w_nb.v0 = 1'b1;
                w_nb.c0 = w_x;
            end else begin
                w_nb.v1 = 1'b1;
                w_nb.c1 = w_x;
            end
        end else begin
            w_ok = w_has;
            if (r_ra.v0 && r_ra.c0 == w_y) w_na.v0 = 1'b0;
            else w_na.v1 = 1'b0;
            if (r_rb.v0 && r_rb.c0 == w_x) w_nb.v0 = 1'b0;
            else w_nb.v1 = 1'b0;
        end

        // one step of the tour walk on the entry just read
        w_fok = r_rdata.v0 && r_rdata.c0 != r_prev;
        w_sok = r_rdata.v1 && r_rdata.c1 != r_prev;
        w_dead = !w_fok && !w_sok;
        w_next = w_fok ? r_rdata.c0 : r_rdata.c1;
        w_slast = (32'(r_steps) + 32'd1) >= 32'(w_n);

        w_has_ab = (r_ra.v0 && r_ra.c0 == w_b) || (r_ra.v1 && r_ra.c1 == w_b);

        unique case (i_cmd.rd_src)
            RS_X:    w_rd_city = w_x;
            RS_Y:    w_rd_city = w_y;
            RS_A:    w_rd_city = w_a;
            RS_CUR:  w_rd_city = r_cur;
            default: w_rd_city = w_a;
        endcase

        o_sts.func = r_func;
        o_sts.range_bad = w_bad;
        o_sts.step_last = w_step.last;
        o_sts.trivial = (w_c == w_b) || (w_c == w_d);
        o_sts.w_done = w_dead || w_next == w_d || w_next == w_c || w_slast;
        o_sts.w_ans = !w_dead && w_next != w_d && w_next == w_c;
        o_sts.clr_last = (r_clr == AW'(MAX_CITIES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) r_rdata <= mem[AW'(w_rd_city)];
        unique case (i_cmd.wr)
            WS_X:    if (w_ok) mem[AW'(w_x)] <= w_na;
            WS_Y:    if (w_ok) mem[AW'(w_y)] <= w_nb;
            WS_CLR:  mem[r_clr] <= '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.wr == WS_CLR) begin
            r_clr <= o_sts.clr_last ? '0 : r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_ops <= i_ops;
            r_err <= 1'b0;
            r_ans <= 1'b0;
        end
        if (i_cmd.lat_a) r_ra <= r_rdata;
        if (i_cmd.lat_b) r_rb <= r_rdata;
        if (i_cmd.edge_done && !w_ok) r_err <= 1'b1;
        if (i_cmd.ans_set) r_ans <= i_cmd.ans_val;
        if (i_cmd.walk_init) begin
            r_prev <= w_a;
            r_cur <= w_b;
            r_steps <= '0;
        end else if (i_cmd.walk_adv) begin
            r_prev <= r_cur;
            r_cur <= w_next;
            r_steps <= r_steps + NW'(1);
        end
        if (i_cmd.out_load) begin
            r_status <= w_bad ? ST_RANGE : (r_err ? ST_REJ : ST_OK);
            if (r_func == F_QUERY) r_answer <= w_has_ab && !w_bad;
            else if (r_func == F_BETWEEN) r_answer <= r_ans;
            else r_answer <= 1'b0;
            r_degree <= (32'(w_a) < 32'(w_n)) ? ({1'b0, r_ra.v0} + {1'b0, r_ra.v1}) : 2'd0;
        end
    end

    assign o_status = r_status;
    assign o_answer = r_answer;
    assign o_degree = r_degree;

endmodule
`default_nettype wire

// ===== hdl/tour_edge_table_k_opt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// query and unused codes read the entry of city a only; add, delete and the exchanges run edge
// steps (up to 8 steps) that each read and write back both entries; between walks the tour (up to city count)
// clear writes one table entry per cycle through the write port until every entry is cleared
// one item at a time: the next item is accepted once the previous result is registered
// reset: synchronous active low; a sweep that clears every table entry follows, inputs stalled
module tour_edge_table_k_opt #(
    parameter int MAX_CITIES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_func,
    input  wire logic [9:0]  i_city_a,
    input  wire logic [9:0]  i_city_b,
    input  wire logic [9:0]  i_city_c,
    input  wire logic [9:0]  i_city_d,
    input  wire logic [9:0]  i_city_e,
    input  wire logic [9:0]  i_city_f,
    input  wire logic [9:0]  i_city_g,
    input  wire logic [9:0]  i_city_h,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_answer,
    output logic [1:0]       o_degree,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tek_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [10:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 11'd1024;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_count <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {21'd0, r_count};

    tek_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tek_dp #(.MAX_CITIES(MAX_CITIES)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_count  (r_count),
        .i_func   (i_func),
        .i_ops    ({i_city_h, i_city_g, i_city_f, i_city_e,
                    i_city_d, i_city_c, i_city_b, i_city_a}),
        .o_status (o_status),
        .o_answer (o_answer),
        .o_degree (o_degree)
    );

    // one item in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    a_degree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_degree != 2'd3))
        else $error("degree above two");

endmodule
`default_nettype wire
